/* sv/rsl_pkg.sv */
// ----------------------------------------------------------------------------
// rsl_pkg: shared types and constants for the residual slew limiter
// Payload structs, field widths, fixed-point constants, register indexes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rsl_pkg;

    // axis count and field widths
    localparam int NUM_AXES  = 6;
    localparam int AXIS_W    = 3;
    localparam int WRENCH_W  = 24;
    localparam int DELTA_W   = 20;
    localparam int ACT_W     = 16;
    localparam int CONF_W    = 16;
    localparam int DT_W      = 16;
    localparam int BLEND_W   = 16;
    localparam int LIM_W     = 10;
    localparam int CFG_W     = 60;
    localparam int CFG_IDX_W = 3;

    // datapath widths
    localparam int MAG_W     = 15;                 // |action| <= 1.0 in Q2.14
    localparam int P1_W      = 24;                 // |a| * limit < 2^24
    localparam int P1_ACC_W  = MAG_W + LIM_W;
    localparam int PR_ACC_W  = DT_W + LIM_W;
    localparam int MAG_ACC_W = P1_W + BLEND_W;
    localparam int ROUND_SH  = 21;                 // Q.29 -> Q.8
    localparam int REQ_MAG_W = MAG_ACC_W - ROUND_SH;
    localparam int STEP_SH   = 8;                  // Q.16 -> Q.8
    localparam int STEP_W    = PR_ACC_W - STEP_SH;
    localparam int DIFF_W    = DELTA_W + 1;

    localparam logic [AXIS_W-1:0] NUM_AXES_V = AXIS_W'(NUM_AXES);

    // fixed-point constants
    localparam logic signed [ACT_W-1:0] ACT_POS_ONE = 16'sd16384;
    localparam logic signed [ACT_W-1:0] ACT_NEG_ONE = -16'sd16384;
    localparam logic [MAG_W-1:0]        MAG_ONE     = 15'd16384;
    localparam logic [BLEND_W-1:0]      BLEND_ONE   = 16'd32768;

    // half-LSB rounding term, preloaded in the upper half of the accumulator
    localparam logic [MAG_ACC_W-1:0] ROUND_INIT =
        MAG_ACC_W'(1) << (ROUND_SH - 1 + BLEND_W);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLED  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_CONF = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLEND    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DLIMITS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RLIMITS  = 3'd4;

    typedef struct packed {
        logic [AXIS_W-1:0]          axis;
        logic signed [WRENCH_W-1:0] base_component;
        logic signed [ACT_W-1:0]    normalized;
        logic                       action_valid;
        logic [CONF_W-1:0]          confidence;
        logic [DT_W-1:0]            step_time;
    } t_in;

    typedef struct packed {
        logic [AXIS_W-1:0]          axis_out;
        logic signed [WRENCH_W-1:0] wrench_out;
        logic                       residual_applied;
    } t_out;

endpackage

`default_nettype wire

/* sv/residual_slew_limiter.sv */
// ----------------------------------------------------------------------------
// residual_slew_limiter: gated, scaled, slew-limited residual on a wrench axis
// Bit-serial multiplies feed a small slew clamp and a saturating add.
// ----------------------------------------------------------------------------
// Sequence: an applied request runs the limit/rate multiply over the 10 limit
//   bits, then the blend multiply over the 16 blend bits, then SLEW, NEWD, DONE.
// A request the gate rejects, or with its axis out of range, goes straight to DONE.
// Flow: one request in flight; a new one is taken only in IDLE, DONE holds while
//   the output is stalled, and the bit-serial shift-add multipliers serve all axes.
// Reset: synchronous, active low; clears config, stored deltas, state, out valid.
`timescale 1ns / 1ps
`default_nettype none

module residual_slew_limiter (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    // request in
    input  wire                                i_in_valid,
    output logic                               o_in_stall,
    input  wire  rsl_pkg::t_in                 i_in_data,
    // result out
    output logic                               o_out_valid,
    input  wire                                i_out_stall,
    output rsl_pkg::t_out                      o_out_data,
    // config write port
    input  wire                                i_cfg_we,
    input  wire  [rsl_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire  [rsl_pkg::CFG_W-1:0]          i_cfg_data
);

    // sequencer codes
    localparam logic [2:0] ST_IDLE = 3'd0;   // waiting for a request
    localparam logic [2:0] ST_MULA = 3'd1;   // |a|*limit and rate*dt, limit bits
    localparam logic [2:0] ST_MULB = 3'd2;   // (|a|*limit)*blend, blend bits
    localparam logic [2:0] ST_SLEW = 3'd3;   // signed request, diff vs stored
    localparam logic [2:0] ST_NEWD = 3'd4;   // slew clamp, write back delta
    localparam logic [2:0] ST_DONE = 3'd5;   // saturating add into out reg

    localparam logic [3:0] MULA_LAST = 4'(rsl_pkg::LIM_W - 1);
    localparam logic [3:0] MULB_LAST = 4'(rsl_pkg::BLEND_W - 1);

    // config registers
    logic                              r_enabled;
    logic [rsl_pkg::CONF_W-1:0]        r_min_conf;
    logic [rsl_pkg::BLEND_W-1:0]       r_blend;
    logic [rsl_pkg::CFG_W-1:0]         r_dlim;
    logic [rsl_pkg::CFG_W-1:0]         r_rlim;

    // stored per-axis deltas, Q12.8
    logic signed [rsl_pkg::DELTA_W-1:0] r_delta [rsl_pkg::NUM_AXES];

    // sequencer
    logic [2:0] r_state, n_state;
    logic [3:0] r_cnt;

    // per-request working registers
    logic [rsl_pkg::AXIS_W-1:0]          r_axis;
    logic signed [rsl_pkg::WRENCH_W-1:0] r_base;
    logic                                r_neg;
    logic                                r_slew_en;
    logic                                r_applied;
    logic [rsl_pkg::MAG_W-1:0]           r_amag;
    logic [rsl_pkg::DT_W-1:0]            r_dt;
    logic [rsl_pkg::LIM_W-1:0]           r_lim;     // shifts right, LSB first
    logic [rsl_pkg::LIM_W-1:0]           r_rate;    // shifts right, LSB first
    logic [rsl_pkg::BLEND_W-1:0]         r_bl;      // shifts right, LSB first
    logic [rsl_pkg::P1_ACC_W-1:0]        r_acc_p1;
    logic [rsl_pkg::PR_ACC_W-1:0]        r_acc_pr;
    logic [rsl_pkg::MAG_ACC_W-1:0]       r_acc_m;
    logic signed [rsl_pkg::DELTA_W-1:0]  r_prev;
    logic signed [rsl_pkg::DELTA_W-1:0]  r_req;
    logic signed [rsl_pkg::DIFF_W-1:0]   r_diff;
    logic signed [rsl_pkg::DELTA_W-1:0]  r_new;

    // output register
    logic          r_out_valid;
    rsl_pkg::t_out r_out;

    // ---------------------------------------------------------------- accept
    logic in_accept;
    logic out_free;
    assign in_accept = i_in_valid && (r_state == ST_IDLE);
    assign out_free  = !r_out_valid || !i_out_stall;

    // gate: axis in range, enabled, action valid, confidence at or above threshold
    logic in_range;
    logic gate_ok;
    assign in_range = i_in_data.axis < rsl_pkg::NUM_AXES_V;
    assign gate_ok  = r_enabled && i_in_data.action_valid &&
                      (i_in_data.confidence >= r_min_conf);

    // per-axis limit fields
    logic [rsl_pkg::CFG_W-1:0] dlim_sh;
    logic [rsl_pkg::CFG_W-1:0] rlim_sh;
    logic [rsl_pkg::LIM_W-1:0] lim_sel;
    logic [rsl_pkg::LIM_W-1:0] rate_sel;
    assign dlim_sh  = r_dlim >> (rsl_pkg::LIM_W * i_in_data.axis);
    assign rlim_sh  = r_rlim >> (rsl_pkg::LIM_W * i_in_data.axis);
    assign lim_sel  = dlim_sh[rsl_pkg::LIM_W-1:0];
    assign rate_sel = rlim_sh[rsl_pkg::LIM_W-1:0];

    // action clamp to +-1.0 and magnitude; blend saturates at 1.0
    logic signed [rsl_pkg::ACT_W-1:0] act_neg;
    logic [rsl_pkg::MAG_W-1:0]        amag_in;
    logic [rsl_pkg::BLEND_W-1:0]      bl_sat;
    assign act_neg = -i_in_data.normalized;

    always_comb begin
        priority if (i_in_data.normalized > rsl_pkg::ACT_POS_ONE) begin
            amag_in = rsl_pkg::MAG_ONE;
        end else if (i_in_data.normalized < rsl_pkg::ACT_NEG_ONE) begin
            amag_in = rsl_pkg::MAG_ONE;
        end else if (i_in_data.normalized[rsl_pkg::ACT_W-1]) begin
            amag_in = act_neg[rsl_pkg::MAG_W-1:0];
        end else begin
            amag_in = i_in_data.normalized[rsl_pkg::MAG_W-1:0];
        end
    end

    assign bl_sat = (r_blend > rsl_pkg::BLEND_ONE) ? rsl_pkg::BLEND_ONE : r_blend;

    // ---------------------------------------------------- shift-add datapath
    // Right-shifting accumulators: only the upper word goes through an adder.
    logic [rsl_pkg::MAG_W:0]     sum_p1;
    logic [rsl_pkg::DT_W:0]      sum_pr;
    logic [rsl_pkg::P1_W:0]      sum_m;
    logic [rsl_pkg::P1_W-1:0]    p1;
    assign p1 = r_acc_p1[rsl_pkg::P1_W-1:0];

    assign sum_p1 = {1'b0, r_acc_p1[rsl_pkg::P1_ACC_W-1:rsl_pkg::LIM_W]}
                  + (r_lim[0] ? {1'b0, r_amag} : '0);
    assign sum_pr = {1'b0, r_acc_pr[rsl_pkg::PR_ACC_W-1:rsl_pkg::LIM_W]}
                  + (r_rate[0] ? {1'b0, r_dt} : '0);
    assign sum_m  = {1'b0, r_acc_m[rsl_pkg::MAG_ACC_W-1:rsl_pkg::BLEND_W]}
                  + (r_bl[0] ? {1'b0, p1} : '0);

    // ----------------------------------------------------- finishing logic
    logic [rsl_pkg::REQ_MAG_W-1:0]      req_mag;
    logic signed [rsl_pkg::DELTA_W-1:0] req_pos;
    logic signed [rsl_pkg::DELTA_W-1:0] req_s;
    logic signed [rsl_pkg::DELTA_W-1:0] prev_rd;
    logic [rsl_pkg::STEP_W-1:0]         step;
    logic signed [rsl_pkg::DIFF_W-1:0]  step_s;
    logic signed [rsl_pkg::DIFF_W-1:0]  diff_cl;
    logic signed [rsl_pkg::DIFF_W-1:0]  new_wide;
    logic signed [rsl_pkg::DELTA_W-1:0] new_d;

    assign req_mag = r_acc_m[rsl_pkg::MAG_ACC_W-1:rsl_pkg::ROUND_SH];
    assign req_pos = {1'b0, req_mag};
    assign req_s   = r_neg ? -req_pos : req_pos;
    assign prev_rd = r_delta[r_axis];

    assign step    = r_acc_pr[rsl_pkg::PR_ACC_W-1:rsl_pkg::STEP_SH];
    assign step_s  = {{(rsl_pkg::DIFF_W - rsl_pkg::STEP_W){1'b0}}, step};

    always_comb begin
        priority if (r_diff > step_s) begin
            diff_cl = step_s;
        end else if (r_diff < -step_s) begin
            diff_cl = -step_s;
        end else begin
            diff_cl = r_diff;
        end
    end

    // result lies between prev and req, so it fits the delta width
    assign new_wide = {r_prev[rsl_pkg::DELTA_W-1], r_prev} + diff_cl;
    assign new_d    = r_slew_en ? new_wide[rsl_pkg::DELTA_W-1:0] : r_req;

    // saturating add to 24 bits
    logic signed [rsl_pkg::WRENCH_W:0]   total_w;
    logic signed [rsl_pkg::WRENCH_W-1:0] total_sat;
    assign total_w = {r_base[rsl_pkg::WRENCH_W-1], r_base}
                   + {{(rsl_pkg::WRENCH_W + 1 - rsl_pkg::DELTA_W)
                       {r_new[rsl_pkg::DELTA_W-1]}}, r_new};

    always_comb begin
        if (total_w[rsl_pkg::WRENCH_W] != total_w[rsl_pkg::WRENCH_W-1]) begin
            total_sat = total_w[rsl_pkg::WRENCH_W]
                      ? {1'b1, {(rsl_pkg::WRENCH_W-1){1'b0}}}
                      : {1'b0, {(rsl_pkg::WRENCH_W-1){1'b1}}};
        end else begin
            total_sat = total_w[rsl_pkg::WRENCH_W-1:0];
        end
    end

    // ------------------------------------------------------------ sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    n_state = (in_range && gate_ok) ? ST_MULA : ST_DONE;
                end
            end
            ST_MULA: begin
                if (r_cnt == MULA_LAST) begin
                    n_state = ST_MULB;
                end
            end
            ST_MULB: begin
                if (r_cnt == MULB_LAST) begin
                    n_state = ST_SLEW;
                end
            end
            ST_SLEW: n_state = ST_NEWD;
            ST_NEWD: n_state = ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state != n_state) begin
                r_cnt <= '0;
            end else begin
                r_cnt <= r_cnt + 4'd1;
            end
        end
    end

    // ----------------------------------------------------- config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled  <= 1'b0;
            r_min_conf <= '0;
            r_blend    <= '0;
            r_dlim     <= '0;
            r_rlim     <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                rsl_pkg::CFG_ENABLED:  r_enabled  <= i_cfg_data[0];
                rsl_pkg::CFG_MIN_CONF: r_min_conf <= i_cfg_data[rsl_pkg::CONF_W-1:0];
                rsl_pkg::CFG_BLEND:    r_blend    <= i_cfg_data[rsl_pkg::BLEND_W-1:0];
                rsl_pkg::CFG_DLIMITS:  r_dlim     <= i_cfg_data;
                rsl_pkg::CFG_RLIMITS:  r_rlim     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // --------------------------------------------------------- delta store
    // A rejected gate on an in-range axis clears every axis; an applied request writes its own.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < rsl_pkg::NUM_AXES; i++) begin
                r_delta[i] <= '0;
            end
        end else if (in_accept && in_range && !gate_ok) begin
            for (int i = 0; i < rsl_pkg::NUM_AXES; i++) begin
                r_delta[i] <= '0;
            end
        end else if (r_state == ST_NEWD) begin
            r_delta[r_axis] <= new_d;
        end
    end

    // ------------------------------------------------------ working payload
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    r_axis    <= i_in_data.axis;
                    r_base    <= i_in_data.base_component;
                    r_neg     <= i_in_data.normalized[rsl_pkg::ACT_W-1];
                    r_amag    <= amag_in;
                    r_dt      <= i_in_data.step_time;
                    r_lim     <= lim_sel;
                    r_rate    <= rate_sel;
                    r_bl      <= bl_sat;
                    r_slew_en <= (rate_sel != '0) && (i_in_data.step_time != '0);
                    r_applied <= in_range && gate_ok;
                    r_acc_p1  <= '0;
                    r_acc_pr  <= '0;
                    r_acc_m   <= rsl_pkg::ROUND_INIT;
                    r_new     <= '0;
                end
            end
            ST_MULA: begin
                r_acc_p1 <= {sum_p1, r_acc_p1[rsl_pkg::LIM_W-1:1]};
                r_acc_pr <= {sum_pr, r_acc_pr[rsl_pkg::LIM_W-1:1]};
                r_lim    <= r_lim >> 1;
                r_rate   <= r_rate >> 1;
            end
            ST_MULB: begin
                r_acc_m <= {sum_m, r_acc_m[rsl_pkg::BLEND_W-1:1]};
                r_bl    <= r_bl >> 1;
            end
            ST_SLEW: begin
                r_req  <= req_s;
                r_prev <= prev_rd;
                r_diff <= {req_s[rsl_pkg::DELTA_W-1], req_s}
                        - {prev_rd[rsl_pkg::DELTA_W-1], prev_rd};
            end
            ST_NEWD: begin
                r_new <= new_d;
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------ output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == ST_DONE) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_DONE) && out_free) begin
            r_out.axis_out         <= r_axis;
            r_out.wrench_out       <= total_sat;
            r_out.residual_applied <= r_applied;
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

/* sv/rsl_checker.sv */
// ----------------------------------------------------------------------------
// rsl_checker: port-level checks for the residual slew limiter
// Output hold under stall, one request in flight, pass-through timing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rsl_checker (
    input wire                 i_clk,
    input wire                 i_rst_n,
    input wire                 i_in_valid,
    input wire                 o_in_stall,
    input wire rsl_pkg::t_in   i_in_data,
    input wire                 o_out_valid,
    input wire                 i_out_stall,
    input wire rsl_pkg::t_out  o_out_data
);

    logic in_acc;
    assign in_acc = i_in_valid && !o_in_stall;

    // a stalled result stays valid
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    // a stalled result does not change
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_data))
        else $error("result changed while stalled");

    // one request in flight: input stalls right after an accept
    a_one_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_in_stall)
        else $error("second request taken while busy");

    // invalid action passes the base through, checked when the output is empty at accept
    a_pass_through: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && !i_in_data.action_valid && !o_out_valid |-> ##2
        (o_out_valid && !o_out_data.residual_applied
         && (o_out_data.wrench_out == $past(i_in_data.base_component, 2))
         && (o_out_data.axis_out == $past(i_in_data.axis, 2))))
        else $error("pass-through result wrong");

endmodule

bind residual_slew_limiter rsl_checker u_rsl_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

`default_nettype wire
